// ----- sv/dttf_pkg.sv -----
// Shared types, constants and helpers for the decimal text to fixed point core.
`timescale 1ns / 1ps

package dttf_pkg;

    // Number of fraction digits kept; the result is the number times 10**FRAC_PLACES (1..4).
    localparam int FRAC_PLACES = 2;

    localparam int POW_F  = 10 ** FRAC_PLACES;
    localparam int POW_W  = $clog2(POW_F + 1);
    localparam int FRAC_W = $clog2(POW_F);
    localparam int CNT_W  = $clog2(FRAC_PLACES + 1);
    localparam int WHOLE_W = 31;
    localparam int MAG_W   = WHOLE_W + POW_W + 1;

    localparam logic [WHOLE_W-1:0] MAG_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_WHOLE = 2'd1,
        PH_FRAC  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    // Parsed fields of one finished string.
    typedef struct packed {
        logic               neg;
        logic               sat;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [CNT_W-1:0]   cnt;
    } t_fin;

    // 10**n for n up to FRAC_PLACES.
    function automatic logic [POW_W-1:0] f_pow10(input logic [CNT_W-1:0] n);
        logic [POW_W+3:0] r;
        r = (POW_W + 4)'(1);
        for (int i = 0; i < FRAC_PLACES; i++) begin
            if (CNT_W'(i) < n) begin
                r = (POW_W + 4)'(r[POW_W-1:0] * (POW_W + 4)'(10));
            end
        end
        return r[POW_W-1:0];
    endfunction

endpackage

// ----- sv/dttf_if.sv -----
// Request channel interfaces for characters in and fixed point results out.
`timescale 1ns / 1ps

interface dttf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface dttf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               overflow;

    modport source (output valid, output value, output overflow, input ready);
    modport sink   (input valid, input value, input overflow, output ready);
endinterface

// ----- sv/dttf_parse.sv -----
// Input register and per-character parser state.
`timescale 1ns / 1ps

module dttf_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dttf_in_if.sink          i_in,
    output logic             o_fin_valid,
    output dttf_pkg::t_fin   o_fin,
    input  logic             i_fin_take
);

    localparam int FM_W = dttf_pkg::FRAC_W + 4;
    localparam int WM_W = dttf_pkg::WHOLE_W + 4;

    logic       r_in_v;
    logic [7:0] r_in_ch;
    logic       r_in_last;

    dttf_pkg::t_phase                  r_phase, n_phase;
    logic                              r_neg, n_neg;
    logic                              r_sat, n_sat;
    logic [dttf_pkg::WHOLE_W-1:0]      r_whole, n_whole;
    logic [dttf_pkg::FRAC_W-1:0]       r_frac, n_frac;
    logic [dttf_pkg::CNT_W-1:0]        r_cnt, n_cnt;

    logic           r_fin_v;
    dttf_pkg::t_fin r_fin;

    logic            w_fin_free;
    logic            w_consume;
    logic            w_digit;
    logic [3:0]      w_d;
    logic [WM_W-1:0] w_wmul;
    logic [FM_W-1:0] w_fmul;

    assign w_fin_free = !r_fin_v || i_fin_take;
    assign w_consume  = r_in_v && w_fin_free;
    assign i_in.ready = !r_in_v || w_consume;

    assign w_digit = (r_in_ch >= dttf_pkg::CH_ZERO) && (r_in_ch <= dttf_pkg::CH_NINE);
    assign w_d     = w_digit ? r_in_ch[3:0] : 4'd0;
    assign w_wmul  = WM_W'(r_whole) * WM_W'(10) + WM_W'(w_d);
    assign w_fmul  = FM_W'(r_frac) * FM_W'(10) + FM_W'(w_d);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_sat   = r_sat;
        n_whole = r_whole;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        case (r_phase)
            dttf_pkg::PH_START: begin
                if (r_in_ch == dttf_pkg::CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = dttf_pkg::PH_WHOLE;
                end else if (w_digit) begin
                    n_whole = w_wmul[dttf_pkg::WHOLE_W-1:0];
                    n_phase = dttf_pkg::PH_WHOLE;
                end else if (r_in_ch == dttf_pkg::CH_POINT) begin
                    n_phase = dttf_pkg::PH_FRAC;
                end else begin
                    n_phase = dttf_pkg::PH_DONE;
                end
            end
            dttf_pkg::PH_WHOLE: begin
                if (w_digit) begin
                    if (w_wmul > WM_W'(dttf_pkg::MAG_MAX)) begin
                        n_whole = dttf_pkg::MAG_MAX;
                        n_sat   = 1'b1;
                    end else begin
                        n_whole = w_wmul[dttf_pkg::WHOLE_W-1:0];
                    end
                end else if (r_in_ch == dttf_pkg::CH_POINT) begin
                    n_phase = dttf_pkg::PH_FRAC;
                end else begin
                    n_phase = dttf_pkg::PH_DONE;
                end
            end
            dttf_pkg::PH_FRAC: begin
                if (w_digit && (r_cnt < dttf_pkg::CNT_W'(dttf_pkg::FRAC_PLACES))) begin
                    n_frac = w_fmul[dttf_pkg::FRAC_W-1:0];
                    n_cnt  = r_cnt + dttf_pkg::CNT_W'(1);
                end else begin
                    n_phase = dttf_pkg::PH_DONE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_ch   <= i_in.ch;
            r_in_last <= i_in.last;
        end
        if (w_consume && r_in_last) begin
            r_fin.neg   <= n_neg;
            r_fin.sat   <= n_sat;
            r_fin.whole <= n_whole;
            r_fin.frac  <= n_frac;
            r_fin.cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_fin_v <= 1'b0;
            r_phase <= dttf_pkg::PH_START;
            r_neg   <= 1'b0;
            r_sat   <= 1'b0;
            r_whole <= '0;
            r_frac  <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_v <= i_in.valid;
            end
            if (w_fin_free) begin
                r_fin_v <= w_consume && r_in_last;
            end
            if (w_consume) begin
                // Start over after the last character of a string.
                if (r_in_last) begin
                    r_phase <= dttf_pkg::PH_START;
                    r_neg   <= 1'b0;
                    r_sat   <= 1'b0;
                    r_whole <= '0;
                    r_frac  <= '0;
                    r_cnt   <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_sat   <= n_sat;
                    r_whole <= n_whole;
                    r_frac  <= n_frac;
                    r_cnt   <= n_cnt;
                end
            end
        end
    end

    assign o_fin_valid = r_fin_v;
    assign o_fin       = r_fin;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= dttf_pkg::CNT_W'(dttf_pkg::FRAC_PLACES))
        else $error("fraction digit count beyond limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_in_last) |=> (r_phase == dttf_pkg::PH_START && r_whole == '0
                                      && r_neg == 1'b0 && r_cnt == '0))
        else $error("parser state not cleared after last character");

    a_sat_holds_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_whole == dttf_pkg::MAG_MAX))
        else $error("saturated whole part is not at maximum");

endmodule

// ----- sv/dttf_scale.sv -----
// Scaling, saturation and sign stage with the result register.
`timescale 1ns / 1ps

module dttf_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fin_valid,
    input  dttf_pkg::t_fin   i_fin,
    output logic             o_fin_take,
    dttf_out_if.source       o_out
);

    localparam int MW = dttf_pkg::MAG_W;

    logic                         r_mag_v;
    logic [dttf_pkg::WHOLE_W-1:0] r_mag;
    logic                         r_mag_ovf;
    logic                         r_mag_neg;

    logic               r_out_v;
    logic signed [31:0] r_value;
    logic               r_ovf;

    logic                     w_en_out;
    logic                     w_take;
    logic [dttf_pkg::CNT_W-1:0] w_pad;
    logic [MW-1:0]            w_mag;
    logic                     w_ovf;

    assign w_en_out   = !r_out_v || o_out.ready;
    assign w_take     = !r_mag_v || w_en_out;
    assign o_fin_take = w_take;

    assign w_pad = dttf_pkg::CNT_W'(dttf_pkg::FRAC_PLACES) - i_fin.cnt;
    assign w_mag = MW'(i_fin.whole) * MW'(dttf_pkg::POW_F)
                 + MW'(i_fin.frac) * MW'(dttf_pkg::f_pow10(w_pad));
    assign w_ovf = i_fin.sat || (w_mag > MW'(dttf_pkg::MAG_MAX));

    always_ff @(posedge i_clk) begin
        if (w_take && i_fin_valid) begin
            r_mag     <= w_ovf ? dttf_pkg::MAG_MAX : w_mag[dttf_pkg::WHOLE_W-1:0];
            r_mag_ovf <= w_ovf;
            r_mag_neg <= i_fin.neg;
        end
        if (w_en_out && r_mag_v) begin
            r_value <= r_mag_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
            r_ovf   <= r_mag_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_take) begin
                r_mag_v <= i_fin_valid;
            end
            if (w_en_out) begin
                r_out_v <= r_mag_v;
            end
        end
    end

    assign o_out.valid    = r_out_v;
    assign o_out.value    = r_value;
    assign o_out.overflow = r_ovf;

    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_ovf) |-> (r_value == 32'sh7FFF_FFFF || r_value == -32'sh7FFF_FFFF))
        else $error("overflow flagged without saturated value");

    a_no_min_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_value != 32'sh8000_0000))
        else $error("result outside symmetric range");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mag_v && w_en_out) |=> r_out_v)
        else $error("scaled value lost between stages");

endmodule

// ----- sv/decimal_text_to_fixed_point_core.sv -----
// Top level: ASCII decimal text to signed fixed point (times 10**FRAC_PLACES).
//
// Input channel i_in carries one ASCII character per request, with last set on
// the final character of a string. An optional minus sign, whole digits, a point
// and up to FRAC_PLACES fraction digits are parsed; parsing stops at the first
// character that does not fit and the rest up to last is ignored.
// Output channel o_out carries one request per string: value is the number
// scaled by 10**FRAC_PLACES (100 by default), saturated to +/-2147483647 with
// overflow set when saturated. An empty string (a lone NUL with last) gives 0.
// Throughput: one character per cycle while the output is not stalled, set by the
// times-ten update of the parser state. A result passes through the input
// register, the parse and scale stages and the result register.
// Reset (synchronous, active low) empties all stages and returns the parser to
// its start state. When the receiver holds ready low, the result stays in the
// output register and the scale and parse stages keep filling behind it;
// input ready drops only once every stage holds a request.
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dttf_in_if.sink    i_in,
    dttf_out_if.source o_out
);

    logic           w_fin_valid;
    logic           w_fin_take;
    dttf_pkg::t_fin w_fin;

    dttf_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_fin_valid (w_fin_valid),
        .o_fin       (w_fin),
        .i_fin_take  (w_fin_take)
    );

    dttf_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (w_fin_valid),
        .i_fin       (w_fin),
        .o_fin_take  (w_fin_take),
        .o_out       (o_out)
    );

endmodule

// ----- dv/testbench.sv -----
// Testbench for the decimal text to fixed point core: directed, stall and random string tests.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF    = 6;
    localparam int RST_CYCLES  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 12;

    typedef struct {
        logic signed [31:0] value;
        logic               overflow;
    } t_fixed_result;

    logic i_clk;
    logic i_rst_n;

    dttf_in_if  in_ch();
    dttf_out_if out_ch();

    decimal_text_to_fixed_point_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Parser state mirrored for prediction
    dttf_pkg::t_phase text_phase;
    logic             text_neg;
    longint unsigned  whole_mag;
    logic             whole_sat;
    int               frac_val;
    int               frac_cnt;

    t_fixed_result expected_fixed[$];

    int  errors;
    int  cycle_cnt;
    int  chars_sent;
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  hold_off_req;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void clear_text_state();
        text_phase = dttf_pkg::PH_START;
        text_neg   = 1'b0;
        whole_mag  = 0;
        whole_sat  = 1'b0;
        frac_val   = 0;
        frac_cnt   = 0;
    endfunction

    function automatic void push_whole_digit(int dv);
        longint unsigned nxt;
        nxt = whole_mag * 10 + dv;
        if (nxt > dttf_pkg::MAG_MAX) begin
            whole_mag = longint'(dttf_pkg::MAG_MAX);
            whole_sat = 1'b1;
        end else begin
            whole_mag = nxt;
        end
    endfunction

    function automatic void parse_text_char(logic [7:0] c, logic is_last);
        logic            is_digit;
        int              dv;
        longint unsigned mag;
        longint unsigned scale;
        logic [31:0]     m32;
        t_fixed_result   r;
        is_digit = (c >= dttf_pkg::CH_ZERO) && (c <= dttf_pkg::CH_NINE);
        dv = is_digit ? int'(c - dttf_pkg::CH_ZERO) : 0;
        case (text_phase)
            dttf_pkg::PH_START: begin
                if (c == dttf_pkg::CH_MINUS) begin
                    text_neg   = 1'b1;
                    text_phase = dttf_pkg::PH_WHOLE;
                end else if (is_digit) begin
                    push_whole_digit(dv);
                    text_phase = dttf_pkg::PH_WHOLE;
                end else if (c == dttf_pkg::CH_POINT) begin
                    text_phase = dttf_pkg::PH_FRAC;
                end else begin
                    text_phase = dttf_pkg::PH_DONE;
                end
            end
            dttf_pkg::PH_WHOLE: begin
                if (is_digit) begin
                    push_whole_digit(dv);
                end else if (c == dttf_pkg::CH_POINT) begin
                    text_phase = dttf_pkg::PH_FRAC;
                end else begin
                    text_phase = dttf_pkg::PH_DONE;
                end
            end
            dttf_pkg::PH_FRAC: begin
                if (is_digit && frac_cnt < dttf_pkg::FRAC_PLACES) begin
                    frac_val = frac_val * 10 + dv;
                    frac_cnt++;
                end else begin
                    text_phase = dttf_pkg::PH_DONE;
                end
            end
            default: ;
        endcase
        if (!is_last) return;
        // Pad a short fraction with zeros, then scale the whole part
        scale = 1;
        for (int i = frac_cnt; i < dttf_pkg::FRAC_PLACES; i++) scale = scale * 10;
        mag = whole_mag;
        for (int i = 0; i < dttf_pkg::FRAC_PLACES; i++) mag = mag * 10;
        mag = mag + longint'(frac_val) * scale;
        r.overflow = whole_sat || (mag > dttf_pkg::MAG_MAX);
        if (r.overflow) mag = longint'(dttf_pkg::MAG_MAX);
        m32 = mag[31:0];
        r.value = text_neg ? $signed(-m32) : $signed(m32);
        expected_fixed.push_back(r);
        clear_text_state();
    endfunction

    // Predict on every accepted character
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            parse_text_char(in_ch.ch, in_ch.last);
        end
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_fixed_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_fixed.size() == 0) begin
                $display("%0t: unexpected result value %0d overflow %0b", $time,
                         out_ch.value, out_ch.overflow);
                errors++;
            end else begin
                exp_r = expected_fixed.pop_front();
                if (out_ch.value !== exp_r.value) begin
                    $display("%0t: value mismatch expected %0d actual %0d", $time,
                             exp_r.value, out_ch.value);
                    errors++;
                end
                if (out_ch.overflow !== exp_r.overflow) begin
                    $display("%0t: overflow mismatch expected %0b actual %0b", $time,
                             exp_r.overflow, out_ch.overflow);
                    errors++;
                end
            end
        end
    end

    // Result receiver: long hold-off on request, else random stall bursts when rx_idle_en is set
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req > 0) begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.ch    <= c;
        in_ch.last  <= is_last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    // An empty string goes out as a lone NUL flagged last
    task automatic send_text(input string s);
        if (s.len() == 0) begin
            send_char(8'h00, 1'b1);
        end else begin
            for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_fixed.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic send_random_string();
        logic [7:0] txt[$];
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) txt.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 1) begin
            txt.push_back(8'h00);
        end else begin
            if ($urandom_range(0, 2) == 0) txt.push_back(dttf_pkg::CH_MINUS);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            repeat (n) txt.push_back(dttf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 0) begin
                txt.push_back(dttf_pkg::CH_POINT);
                n = $urandom_range(0, 4);
                repeat (n) txt.push_back(dttf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            // Break the tail now and then
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0:       txt.push_back(dttf_pkg::CH_MINUS);
                        1:       txt.push_back(dttf_pkg::CH_POINT);
                        2:       txt.push_back(dttf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                        default: txt.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            if (txt.size() == 0) begin
                txt.push_back(dttf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic test_directed();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_text("0");
        send_text("9");
        send_text("-");
        send_text(".");
        send_text("");
        send_text("x");
        send_text(".5");
        send_text("-0");
        send_text("-12.34");
        send_text("3.1");
        send_text("12.345");
        send_text("--5");
        send_text("5-3");
        send_text("1.2.3");
        send_text("21474836.47");
        send_text("21474836.48");
        send_text("-99999999999");
        send_char(8'hFF, 1'b1);
        send_char(8'h80, 1'b1);
        wait_results_drained();
    endtask

    // Hold the receiver off so the pipeline fills and input ready drops
    task automatic test_input_stall();
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_off_req = 150;
        repeat (24) send_char(dttf_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_idle();
        int stop_at;
        bit paused;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        stop_at = chars_sent + 600;
        paused  = 1'b0;
        while (chars_sent < stop_at) begin
            send_random_string();
            // Pause the sender until every result is back, once midway
            if (!paused && chars_sent >= stop_at - 300) begin
                paused = 1'b1;
                wait_results_drained();
            end
        end
        wait_results_drained();
    endtask

    task automatic test_random_steady();
        int stop_at;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        stop_at = chars_sent + 180;
        while (chars_sent < stop_at) send_random_string();
        wait_results_drained();
    endtask

    initial begin
        errors       = 0;
        cycle_cnt    = 0;
        chars_sent   = 0;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_off_req = 0;
        clear_text_state();
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.ch    <= 8'h00;
        in_ch.last  <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_input_stall();
        test_random_idle();
        test_random_steady();

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- decimal_text_to_fixed_point_core.f -----
sv/dttf_pkg.sv
sv/dttf_if.sv
sv/dttf_parse.sv
sv/dttf_scale.sv
sv/decimal_text_to_fixed_point_core.sv
dv/testbench.sv
